[rtl/llrp_pkg.sv]
// shared types, constants and helpers for the least loaded replica picker
// no dependencies
package llrp_pkg;

	localparam int MAX_SERVERS_DEF = 64;
	localparam int LOAD_W          = 8;
	localparam int PORT_W          = 16;
	localparam int IDX_OUT_W       = 6;
	localparam int FIXED_JOINS     = 3;

	localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

	typedef struct packed {
		logic              done;
		logic [LOAD_W-1:0] load;
	} scan_res_t;

	function automatic logic [LOAD_W-1:0] sat_inc(input logic [LOAD_W-1:0] v);
		logic [LOAD_W-1:0] r;
		r = (v == LOAD_MAX) ? v : v + LOAD_W'(1);
		return r;
	endfunction

endpackage

[rtl/llrp_ram.sv]
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module llrp_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/llrp_scan.sv]
// least load scan unit: walks load entries one a cycle, keeps the running minimum
// depends on llrp_pkg
module llrp_scan #(
	parameter int IW = 6,
	parameter int CW = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [CW-1:0]             limit,
	input  logic [IW-1:0]             skip,
	input  logic                      skip_en,
	output logic [IW-1:0]             raddr,
	input  logic [llrp_pkg::LOAD_W-1:0] rload,
	output llrp_pkg::scan_res_t       res,
	output logic [IW-1:0]             best_idx
);
	import llrp_pkg::*;

	logic              busy_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     limit_q;
	logic [IW-1:0]     skip_q;
	logic              skip_en_q;
	logic              v_s1;
	logic [IW-1:0]     idx_s1;
	logic [LOAD_W:0]   best_q;
	logic [IW-1:0]     bidx_q;
	logic              issue;
	logic              take;

	assign issue = busy_q && (i_q < limit_q);
	assign raddr = i_q[IW-1:0];
	assign take  = v_s1 && !(skip_en_q && (idx_s1 == skip_q))
		&& ({1'b0, rload} < best_q);

	assign res.done  = busy_q && !issue && !v_s1;
	assign res.load  = best_q[LOAD_W-1:0];
	assign best_idx  = bidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			v_s1   <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			v_s1   <= 1'b0;
			i_q    <= '0;
		end else if (busy_q) begin
			v_s1 <= issue;
			if (issue) begin
				i_q <= i_q + CW'(1);
			end
			if (res.done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			limit_q   <= limit;
			skip_q    <= skip;
			skip_en_q <= skip_en;
			best_q    <= {1'b1, {LOAD_W{1'b0}}};
			bidx_q    <= '0;
		end else begin
			idx_s1 <= i_q[IW-1:0];
			if (take) begin
				best_q <= {1'b0, rload};
				bidx_q <= idx_s1;
			end
		end
	end

endmodule

[rtl/least_loaded_replica_picker.sv]
// top level of the least loaded replica picker: sequencer, tables and result register
// depends on llrp_pkg, llrp_ram, llrp_scan
//
// Each input item is a join carrying the new server's port; each join yields
// exactly one result item. The input channel is ready only while the
// sequencer is idle. The result sits in an output register, so the next join
// can be taken while a result still waits for out_ready.
// For a join with n servers already known: refused joins and the first join
// go straight to the result stage, the second and third write fixed loads,
// and later joins make two passes of the scan unit over the load table at one
// entry a cycle. The sequencer returns to idle after each result is written
// and takes the next join only from there.
// Reset clears the server count, the load valid bits and the sequencer; the
// port table is not cleared. While the receiver stalls, a finished result
// holds and the sequencer waits before writing a new one.
module least_loaded_replica_picker #(
	parameter int MAX_SERVERS = llrp_pkg::MAX_SERVERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [llrp_pkg::PORT_W-1:0]    join_port,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [llrp_pkg::IDX_OUT_W-1:0] assigned_index,
	output logic                           first_valid,
	output logic [llrp_pkg::IDX_OUT_W-1:0] first_index,
	output logic [llrp_pkg::PORT_W-1:0]    first_port,
	output logic                           second_valid,
	output logic [llrp_pkg::IDX_OUT_W-1:0] second_index,
	output logic [llrp_pkg::PORT_W-1:0]    second_port,
	output logic                           table_full
);
	import llrp_pkg::*;

	localparam int IW = $clog2(MAX_SERVERS);
	localparam int CW = $clog2(MAX_SERVERS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FIX   = 4'd1;
	localparam logic [3:0] S_SCAN1 = 4'd2;
	localparam logic [3:0] S_BUMP1 = 4'd3;
	localparam logic [3:0] S_SCAN2 = 4'd4;
	localparam logic [3:0] S_BUMP2 = 4'd5;
	localparam logic [3:0] S_RDA   = 4'd6;
	localparam logic [3:0] S_RDB   = 4'd7;
	localparam logic [3:0] S_RDC   = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	logic [3:0]             state_q;
	logic [CW-1:0]          count_q;
	logic                   full_q;
	logic [IW-1:0]          a_q;
	logic [IW-1:0]          b_q;
	logic [IW-1:0]          k_q;
	logic [LOAD_W-1:0]      aload_q;
	logic [LOAD_W-1:0]      bload_q;
	logic [PORT_W-1:0]      pa_q;
	logic [PORT_W-1:0]      pb_q;
	logic [MAX_SERVERS-1:0] vld_q;
	logic                   vld_s1;
	logic                   out_valid_q;

	logic                   accept;
	logic                   full_now;
	logic                   commit;
	logic                   scan_start;
	logic [IW-1:0]          scan_raddr;
	logic [IW-1:0]          scan_idx;
	scan_res_t              scan_res;
	logic [LOAD_W-1:0]      load_rd;
	logic [LOAD_W-1:0]      load_eff;
	logic                   lwe;
	logic [IW-1:0]          lwaddr;
	logic [LOAD_W-1:0]      lwdata;
	logic [PORT_W-1:0]      port_rd;
	logic [IW-1:0]          praddr;
	logic [IW+IDX_OUT_W-1:0] n_ext;
	logic [IW+IDX_OUT_W-1:0] a_ext;
	logic [IW+IDX_OUT_W-1:0] b_ext;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign full_now   = (count_q >= CW'(MAX_SERVERS));
	assign commit     = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign scan_start = (accept && !full_now && (count_q >= CW'(FIXED_JOINS)))
		|| (state_q == S_BUMP1);
	assign out_valid  = out_valid_q;

	// fixed pairings: joins two and three leave every known load equal to n; scans bump their picks
	always_comb begin
		lwe    = 1'b0;
		lwaddr = b_q;
		lwdata = sat_inc(bload_q);
		case (state_q)
			S_FIX: begin
				lwe    = 1'b1;
				lwaddr = k_q;
				lwdata = LOAD_W'(count_q);
			end
			S_BUMP1: begin
				lwe    = 1'b1;
				lwaddr = a_q;
				lwdata = sat_inc(aload_q);
			end
			S_BUMP2: begin
				lwe = 1'b1;
			end
			default: begin
				lwe = 1'b0;
			end
		endcase
	end

	assign load_eff = vld_s1 ? load_rd : '0;
	assign praddr   = (state_q == S_RDA) ? a_q : b_q;

	llrp_ram #(
		.W (LOAD_W),
		.D (MAX_SERVERS)
	) u_load_ram (
		.clk   (clk),
		.we    (lwe),
		.waddr (lwaddr),
		.wdata (lwdata),
		.raddr (scan_raddr),
		.rdata (load_rd)
	);

	llrp_ram #(
		.W (PORT_W),
		.D (MAX_SERVERS)
	) u_port_ram (
		.clk   (clk),
		.we    (accept && !full_now),
		.waddr (count_q[IW-1:0]),
		.wdata (join_port),
		.raddr (praddr),
		.rdata (port_rd)
	);

	llrp_scan #(
		.IW (IW),
		.CW (CW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.limit    (count_q),
		.skip     (a_q),
		.skip_en  (state_q == S_BUMP1),
		.raddr    (scan_raddr),
		.rload    (load_eff),
		.res      (scan_res),
		.best_idx (scan_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (lwe) begin
			vld_q[lwaddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= vld_q[scan_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (full_now || (count_q == '0)) begin
							state_q <= S_FIN;
						end else if (count_q < CW'(FIXED_JOINS)) begin
							state_q <= S_FIX;
						end else begin
							state_q <= S_SCAN1;
						end
					end
				end
				S_FIX: begin
					if (k_q == count_q[IW-1:0]) begin
						state_q <= S_RDA;
					end
				end
				S_SCAN1: begin
					if (scan_res.done) begin
						state_q <= S_BUMP1;
					end
				end
				S_BUMP1: begin
					state_q <= S_SCAN2;
				end
				S_SCAN2: begin
					if (scan_res.done) begin
						state_q <= S_BUMP2;
					end
				end
				S_BUMP2: begin
					state_q <= S_RDA;
				end
				S_RDA: begin
					state_q <= S_RDB;
				end
				S_RDB: begin
					state_q <= S_RDC;
				end
				S_RDC: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (commit) begin
						state_q <= S_IDLE;
						if (!full_q) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					full_q <= full_now;
					a_q    <= (count_q == CW'(2)) ? IW'(1) : '0;
					b_q    <= '0;
					k_q    <= '0;
				end
			end
			S_FIX: begin
				k_q <= k_q + IW'(1);
			end
			S_SCAN1: begin
				if (scan_res.done) begin
					a_q     <= scan_idx;
					aload_q <= scan_res.load;
				end
			end
			S_SCAN2: begin
				if (scan_res.done) begin
					b_q     <= scan_idx;
					bload_q <= scan_res.load;
				end
			end
			S_RDB: begin
				pa_q <= port_rd;
			end
			S_RDC: begin
				pb_q <= port_rd;
			end
			default: begin
			end
		endcase
	end

	assign n_ext = {{IDX_OUT_W{1'b0}}, count_q[IW-1:0]};
	assign a_ext = {{IDX_OUT_W{1'b0}}, a_q};
	assign b_ext = {{IDX_OUT_W{1'b0}}, b_q};

	// result register
	always_ff @(posedge clk) begin
		if (commit) begin
			table_full <= full_q;
			if (full_q) begin
				assigned_index <= '0;
				first_valid    <= 1'b0;
				first_index    <= '0;
				first_port     <= '0;
				second_valid   <= 1'b0;
				second_index   <= '0;
				second_port    <= '0;
			end else begin
				assigned_index <= n_ext[IDX_OUT_W-1:0];
				first_valid    <= (count_q != '0);
				first_index    <= (count_q != '0) ? a_ext[IDX_OUT_W-1:0] : '0;
				first_port     <= (count_q != '0) ? pa_q : '0;
				second_valid   <= (count_q >= CW'(2));
				second_index   <= (count_q >= CW'(2)) ? b_ext[IDX_OUT_W-1:0] : '0;
				second_port    <= (count_q >= CW'(2)) ? pb_q : '0;
			end
		end
	end

endmodule

[tb/least_loaded_replica_picker_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for least_loaded_replica_picker: joins with random ports under
// random stalls on both channels, checked against a placement tracker; needs llrp_pkg and the rtl

module least_loaded_replica_picker_tb;
	import llrp_pkg::*;

	localparam int SERVERS      = MAX_SERVERS_DEF;
	localparam int PHASE_JOINS  = 600;
	localparam int MAX_GAP      = 40;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] assigned_index;
		logic                 first_valid;
		logic [IDX_OUT_W-1:0] first_index;
		logic [PORT_W-1:0]    first_port;
		logic                 second_valid;
		logic [IDX_OUT_W-1:0] second_index;
		logic [PORT_W-1:0]    second_port;
		logic                 table_full;
	} placement_t;

	class placement_tracker;
		int                known;
		logic [LOAD_W-1:0] load [SERVERS];
		logic [PORT_W-1:0] port_of [SERVERS];
		placement_t        expected_placements [$];
		int                mismatch_count;

		function new();
			known = 0;
			mismatch_count = 0;
			foreach (load[i]) begin
				load[i] = '0;
				port_of[i] = '0;
			end
		endfunction

		function void bump(int idx);
			if (load[idx] != '1)
				load[idx] = load[idx] + 1'b1;
		endfunction

		function int lightest(int limit, int skip);
			int best;
			int best_load;
			best = 0;
			best_load = 256;
			for (int i = 0; i < limit; i++)
				if (i != skip && load[i] < best_load) begin
					best_load = load[i];
					best = i;
				end
			return best;
		endfunction

		function void note_join(logic [PORT_W-1:0] port);
			placement_t p;
			int a;
			int b;
			p = '0;
			a = 0;
			b = 0;
			if (known >= SERVERS) begin
				p.table_full = 1'b1;
			end else begin
				port_of[known] = port;
				p.assigned_index = known[IDX_OUT_W-1:0];
				if (known == 1) begin
					p.first_valid = 1'b1;
					load[1] = LOAD_W'(1);
					bump(0);
				end else if (known == 2) begin
					p.first_valid = 1'b1;
					p.second_valid = 1'b1;
					a = 1;
					b = 0;
					bump(2);
					bump(2);
					bump(0);
					bump(1);
				end else if (known >= 3) begin
					p.first_valid = 1'b1;
					p.second_valid = 1'b1;
					a = lightest(known, -1);
					bump(a);
					b = lightest(known, a);
					bump(b);
				end
				if (p.first_valid) begin
					p.first_index = a[IDX_OUT_W-1:0];
					p.first_port = port_of[a];
				end
				if (p.second_valid) begin
					p.second_index = b[IDX_OUT_W-1:0];
					p.second_port = port_of[b];
				end
				known++;
			end
			expected_placements.push_back(p);
		endfunction

		function int pending();
			return expected_placements.size();
		endfunction

		function void report(string field, longint unsigned want, longint unsigned seen);
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
			mismatch_count++;
		endfunction

		function void check_placement(placement_t seen);
			placement_t want;
			if (expected_placements.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, seen);
				mismatch_count++;
				return;
			end
			want = expected_placements.pop_front();
			if (seen.assigned_index !== want.assigned_index)
				report("assigned_index", want.assigned_index, seen.assigned_index);
			if (seen.first_valid !== want.first_valid)
				report("first_valid", want.first_valid, seen.first_valid);
			if (seen.first_index !== want.first_index)
				report("first_index", want.first_index, seen.first_index);
			if (seen.first_port !== want.first_port)
				report("first_port", want.first_port, seen.first_port);
			if (seen.second_valid !== want.second_valid)
				report("second_valid", want.second_valid, seen.second_valid);
			if (seen.second_index !== want.second_index)
				report("second_index", want.second_index, seen.second_index);
			if (seen.second_port !== want.second_port)
				report("second_port", want.second_port, seen.second_port);
			if (seen.table_full !== want.table_full)
				report("table_full", want.table_full, seen.table_full);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PORT_W-1:0]    join_port = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [IDX_OUT_W-1:0] assigned_index;
	logic                 first_valid;
	logic [IDX_OUT_W-1:0] first_index;
	logic [PORT_W-1:0]    first_port;
	logic                 second_valid;
	logic [IDX_OUT_W-1:0] second_index;
	logic [PORT_W-1:0]    second_port;
	logic                 table_full;

	int send_idle_pct = 34;
	int recv_idle_pct = 85;
	int recv_hold = 0;
	placement_tracker tracker = new();

	least_loaded_replica_picker #(
		.MAX_SERVERS(SERVERS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.join_port(join_port),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.assigned_index(assigned_index),
		.first_valid(first_valid),
		.first_index(first_index),
		.first_port(first_port),
		.second_valid(second_valid),
		.second_index(second_index),
		.second_port(second_port),
		.table_full(table_full)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic offer_join(input logic [PORT_W-1:0] port);
		in_valid <= 1'b1;
		join_port <= port;
		do @(posedge clk); while (!in_ready);
		tracker.note_join(port);
	endtask

	task automatic sender_gap();
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct && gap < MAX_GAP)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_joins(input int count);
		repeat (count) begin
			sender_gap();
			offer_join(PORT_W'($urandom));
		end
	endtask

	task automatic wait_all_placed();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// receiver side, with a long hold-off when recv_hold is loaded
	initial begin
		placement_t seen;
		wait (arst_n);
		forever begin
			if (recv_hold > 0) begin
				out_ready <= 1'b0;
				recv_hold--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (out_valid && out_ready) begin
				seen.assigned_index = assigned_index;
				seen.first_valid = first_valid;
				seen.first_index = first_index;
				seen.first_port = first_port;
				seen.second_valid = second_valid;
				seen.second_index = second_index;
				seen.second_port = second_port;
				seen.table_full = table_full;
				tracker.check_placement(seen);
			end
		end
	end

	initial begin
		logic [PORT_W-1:0] corner_ports [12];
		corner_ports = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000,
			16'h00FF, 16'hFF00, 16'h7FFF, 16'hFFFE, 16'h0F0F, 16'hF0F0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first, second and third joins plus port extremes
		foreach (corner_ports[i]) begin
			sender_gap();
			offer_join(corner_ports[i]);
		end

		// receiver stalls long while joins keep coming, so the input backs up
		recv_hold = 1500;
		send_joins(PHASE_JOINS);
		wait_all_placed();

		send_idle_pct = 85;
		recv_idle_pct = 34;
		send_joins(PHASE_JOINS);
		wait_all_placed();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 300;
		send_joins(PHASE_JOINS);
		in_valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("%0t: timeout", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
